/* rtl/core/escape_sequence_decoder_defines.svh */
// Assertion helpers for the escape sequence decoder.
`ifndef ESCAPE_SEQUENCE_DECODER_DEFINES_SVH
`define ESCAPE_SEQUENCE_DECODER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ESD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define ESD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/esd_pkg.sv */
package esd_pkg;

   typedef enum logic [1:0] {
      MODE_NORMAL = 2'd0,
      MODE_ESCAPE = 2'd1,
      MODE_OCTAL  = 2'd2,
      MODE_HEX    = 2'd3
   } mode_type;

   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_0         = 8'h30;
   localparam logic [7:0] CHAR_7         = 8'h37;
   localparam logic [7:0] CHAR_9         = 8'h39;
   localparam logic [7:0] CHAR_LA        = 8'h61;
   localparam logic [7:0] CHAR_LB        = 8'h62;
   localparam logic [7:0] CHAR_LF        = 8'h66;
   localparam logic [7:0] CHAR_LN        = 8'h6E;
   localparam logic [7:0] CHAR_LR        = 8'h72;
   localparam logic [7:0] CHAR_LT        = 8'h74;
   localparam logic [7:0] CHAR_LV        = 8'h76;
   localparam logic [7:0] CHAR_UA        = 8'h41;
   localparam logic [7:0] CHAR_UF        = 8'h46;
   localparam logic [7:0] CHAR_FF        = 8'h0C;
   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_VT        = 8'h0B;
   localparam logic [7:0] CHAR_NL        = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_BS        = 8'h08;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_NUL       = 8'h00;

   // Bit 8: digit is valid, bits 3:0: its value.
   function automatic logic [8:0] hex_digit(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      if (c inside {[CHAR_0:CHAR_9]}) begin
         r = {1'b1, 4'b0, c[3:0]};
      end else if (c inside {[CHAR_LA:CHAR_LF]} || c inside {[CHAR_UA:CHAR_UF]}) begin
         // letters a-f and A-F share the low nibble 1..6
         r = {1'b1, 4'b0, c[3:0] + 4'd9};
      end
      return r;
   endfunction

   // Bit 8: a simple escape letter, bits 7:0: the byte it stands for.
   function automatic logic [8:0] simple_escape(input logic [7:0] c);
      logic [8:0] r;
      r = '0;
      case (c)
         CHAR_LF:        r = {1'b1, CHAR_FF};
         CHAR_LR:        r = {1'b1, CHAR_CR};
         CHAR_LV:        r = {1'b1, CHAR_VT};
         CHAR_LN:        r = {1'b1, CHAR_NL};
         CHAR_LT:        r = {1'b1, CHAR_TAB};
         CHAR_LB:        r = {1'b1, CHAR_BS};
         CHAR_BACKSLASH: r = {1'b1, CHAR_BACKSLASH};
         CHAR_DQUOTE:    r = {1'b1, CHAR_DQUOTE};
         CHAR_SQUOTE:    r = {1'b1, CHAR_SQUOTE};
         default:        r = '0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/core/escape_sequence_decoder.sv */
// Channel   Dir  tdata              tlast            Accepted when
// req       in   [7:0] data_byte    end_of_string    req_tvalid & req_tready
// rsp       out  [7:0] out_byte     out_last         rsp_tvalid & rsp_tready
//
// A request is held in an input register, decoded in one pass, and its results
// (zero to three bytes) are loaded together into a result bundle register.
// The bundle drains one byte per cycle while rsp_tready is high; meanwhile the
// following request waits in the input register.
// The next request is taken while the last byte of a bundle is being taken.
// Reset (synchronous, active high) clears the decode state and both valid flags.
// A stalled rsp side holds the bundle and, once the input register is full,
// drops req_tready.
`include "escape_sequence_decoder_defines.svh"

module escape_sequence_decoder
   import esd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // out_last
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // decode state
   mode_type   mode_ff, mode_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] accum_ff, accum_in;

   // result bundle
   logic [7:0] bun_byte_ff [MAX_RESULTS];
   logic       bun_last_ff [MAX_RESULTS];
   logic [1:0] bun_cnt_ff, bun_cnt_in;
   logic [1:0] bun_idx_ff, bun_idx_in;

   // decode results
   logic [7:0] res_byte [MAX_RESULTS];
   logic       res_last [MAX_RESULTS];
   logic [1:0] res_cnt;

   // state after the character, before end-of-string handling
   mode_type   mode_step;
   logic [7:0] accum_step;

   logic       rsp_fire, drain_done, bundle_free, load;
   logic [8:0] hex_r, esc_r;
   logic       is_octal;
   logic [7:0] oct_accum, hex_accum;

   // ---------------------------------------------------------------- handshake
   assign rsp_tvalid  = (bun_cnt_ff != 2'd0);
   assign rsp_tdata   = bun_byte_ff[bun_idx_ff];
   assign rsp_tlast   = bun_last_ff[bun_idx_ff];
   assign rsp_fire    = rsp_tvalid && rsp_tready;
   assign drain_done  = rsp_fire && (bun_idx_ff == bun_cnt_ff - 2'd1);
   assign bundle_free = (bun_cnt_ff == 2'd0) || drain_done;
   assign load        = in_valid_ff && bundle_free;
   assign req_tready  = !in_valid_ff || load;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !load);

   // ---------------------------------------------------------------- digit decode
   assign hex_r     = hex_digit(in_byte_ff);
   assign esc_r     = simple_escape(in_byte_ff);
   assign is_octal  = in_byte_ff inside {[CHAR_0:CHAR_7]};
   assign oct_accum = {accum_ff[4:0], in_byte_ff[2:0]};
   assign hex_accum = {accum_ff[3:0], hex_r[3:0]};

   // ---------------------------------------------------------------- next state
   always_comb begin
      mode_step  = mode_ff;
      count_in   = count_ff;
      accum_step = accum_ff;
      case (mode_ff)
         MODE_NORMAL: begin
            if (in_byte_ff == CHAR_BACKSLASH) mode_step = MODE_ESCAPE;
         end
         MODE_ESCAPE: begin
            mode_step = MODE_NORMAL;
            if (esc_r[8]) begin
               mode_step = MODE_NORMAL;
            end else if (in_byte_ff == CHAR_X) begin
               mode_step  = MODE_HEX;
               count_in   = 2'd0;
               accum_step = '0;
            end else if (is_octal) begin
               mode_step  = MODE_OCTAL;
               count_in   = 2'd1;
               accum_step = {5'b0, in_byte_ff[2:0]};
            end
         end
         MODE_OCTAL: begin
            if (is_octal && count_ff != 2'd2) begin
               count_in   = count_ff + 2'd1;
               accum_step = oct_accum;
            end else begin
               // escape complete or ended early; the char may open a new one
               count_in   = 2'd0;
               accum_step = '0;
               mode_step  = (!is_octal && in_byte_ff == CHAR_BACKSLASH)
                            ? MODE_ESCAPE : MODE_NORMAL;
            end
         end
         MODE_HEX: begin
            if (hex_r[8] && count_ff != 2'd1) begin
               count_in   = count_ff + 2'd1;
               accum_step = hex_accum;
            end else begin
               count_in   = 2'd0;
               accum_step = '0;
               mode_step  = (!hex_r[8] && in_byte_ff == CHAR_BACKSLASH)
                            ? MODE_ESCAPE : MODE_NORMAL;
            end
         end
         default: mode_step = MODE_NORMAL;
      endcase
      mode_in  = mode_step;
      accum_in = accum_step;
      if (in_end_ff) begin
         // terminator returns everything to reset values
         mode_in  = MODE_NORMAL;
         count_in = 2'd0;
         accum_in = '0;
      end
   end

   // ---------------------------------------------------------------- results
   always_comb begin
      logic [1:0] n;
      n = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_byte[i] = '0;
         res_last[i] = 1'b0;
      end
      case (mode_ff)
         MODE_NORMAL: begin
            if (in_byte_ff != CHAR_BACKSLASH) begin
               res_byte[n] = in_byte_ff;
               n = n + 2'd1;
            end
         end
         MODE_ESCAPE: begin
            if (esc_r[8]) begin
               res_byte[n] = esc_r[7:0];
               n = n + 2'd1;
            end else if (in_byte_ff != CHAR_X && !is_octal) begin
               // unknown escape: keep backslash and the char
               res_byte[n] = CHAR_BACKSLASH;
               n = n + 2'd1;
               res_byte[n] = in_byte_ff;
               n = n + 2'd1;
            end
         end
         MODE_OCTAL: begin
            if (is_octal) begin
               if (count_ff == 2'd2) begin
                  res_byte[n] = oct_accum;
                  n = n + 2'd1;
               end
            end else begin
               res_byte[n] = accum_ff;
               n = n + 2'd1;
               if (in_byte_ff != CHAR_BACKSLASH) begin
                  res_byte[n] = in_byte_ff;
                  n = n + 2'd1;
               end
            end
         end
         MODE_HEX: begin
            if (hex_r[8]) begin
               if (count_ff == 2'd1) begin
                  res_byte[n] = hex_accum;
                  n = n + 2'd1;
               end
            end else begin
               res_byte[n] = accum_ff;
               n = n + 2'd1;
               if (in_byte_ff != CHAR_BACKSLASH) begin
                  res_byte[n] = in_byte_ff;
                  n = n + 2'd1;
               end
            end
         end
         default: n = 2'd0;
      endcase
      if (in_end_ff) begin
         // flush a pending numeric value, drop a pending backslash
         if (mode_step == MODE_OCTAL || mode_step == MODE_HEX) begin
            res_byte[n] = accum_step;
            n = n + 2'd1;
         end
         res_byte[n] = CHAR_NUL;
         res_last[n] = 1'b1;
         n = n + 2'd1;
      end
      res_cnt = n;
   end

   // ---------------------------------------------------------------- bundle control
   always_comb begin
      bun_cnt_in = bun_cnt_ff;
      bun_idx_in = bun_idx_ff;
      if (load) begin
         bun_cnt_in = res_cnt;
         bun_idx_in = 2'd0;
      end else if (drain_done) begin
         bun_cnt_in = 2'd0;
         bun_idx_in = 2'd0;
      end else if (rsp_fire) begin
         bun_idx_in = bun_idx_ff + 2'd1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         count_ff    <= 2'd0;
         accum_ff    <= '0;
         bun_cnt_ff  <= 2'd0;
         bun_idx_ff  <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         bun_cnt_ff  <= bun_cnt_in;
         bun_idx_ff  <= bun_idx_in;
         if (load) begin
            mode_ff  <= mode_in;
            count_ff <= count_in;
            accum_ff <= accum_in;
         end
      end
   end

   // payload: capture request, load bundle
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (load) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            bun_byte_ff[i] <= res_byte[i];
            bun_last_ff[i] <= res_last[i];
         end
      end
   end

   // ---------------------------------------------------------------- checks
   `ESD_ASSERT_NOW(a_idx_in_range, clock, reset, bun_cnt_ff != 2'd0,
      bun_idx_ff < bun_cnt_ff, "bundle index beyond its fill")
   `ESD_ASSERT_NOW(a_last_is_final, clock, reset, rsp_tvalid && rsp_tlast,
      bun_idx_ff == bun_cnt_ff - 2'd1, "terminator not the final byte of its bundle")
   `ESD_ASSERT_NEXT(a_end_resets, clock, reset, load && in_end_ff,
      mode_ff == MODE_NORMAL && count_ff == 2'd0 && accum_ff == 8'd0,
      "decode state not cleared after end of string")
   `ESD_ASSERT_NOW(a_count_idle, clock, reset,
      mode_ff == MODE_NORMAL || mode_ff == MODE_ESCAPE,
      count_ff == 2'd0, "digit count left over outside a numeric escape")

endmodule
